// ----- hdl/kct_pkg.sv -----
package kct_pkg;

  // Scratch memory: 128 words of 32 bits.
  localparam int MEM_DEPTH = 128;
  localparam int MEM_AW    = 7;

  // Scratch memory map (4x4 matrices are row-major).
  localparam logic [MEM_AW-1:0] ADR_X  = 7'd0;    // state vector
  localparam logic [MEM_AW-1:0] ADR_P  = 7'd4;    // covariance
  localparam logic [MEM_AW-1:0] ADR_F  = 7'd20;   // transition matrix
  localparam logic [MEM_AW-1:0] ADR_A  = 7'd36;   // F * P
  localparam logic [MEM_AW-1:0] ADR_PP = 7'd52;   // predicted covariance
  localparam logic [MEM_AW-1:0] ADR_B  = 7'd68;   // I - K H
  localparam logic [MEM_AW-1:0] ADR_PN = 7'd84;   // corrected covariance
  localparam logic [MEM_AW-1:0] ADR_XP = 7'd100;  // predicted state
  localparam logic [MEM_AW-1:0] ADR_E  = 7'd104;  // innovation
  localparam logic [MEM_AW-1:0] ADR_S  = 7'd106;  // s00 s01 s10 s11
  localparam logic [MEM_AW-1:0] ADR_SI = 7'd110;  // inverse of S
  localparam logic [MEM_AW-1:0] ADR_K  = 7'd114;  // gain, k[i][j] at 2i+j
  localparam logic [MEM_AW-1:0] ADR_XN = 7'd122;  // corrected state

  // Configuration register indexes
  localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd1;
  localparam logic [1:0] CFG_PROC_NOISE = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_SING = 2'd1;
  localparam logic [1:0] STS_SAT  = 2'd2;

  typedef enum logic [1:0] {K_NOP, K_MAC, K_ADD, K_DIV} kind_t;

  typedef enum logic [3:0] {
    SRC_MEM, SRC_DT, SRC_R, SRC_Q, SRC_ONE, SRC_ZERO,
    SRC_PX, SRC_PY, SRC_VX, SRC_VY
  } src_t;

  typedef struct packed {
    kind_t              kind;
    src_t               src;
    logic [MEM_AW-1:0]  a_adr;
    logic [MEM_AW-1:0]  b_adr;
    logic [MEM_AW-1:0]  dst;
    logic               clr;    // start a new sum
    logic               neg;    // subtract the term
    logic               wr;     // store the saturated sum
    logic               det;    // capture the raw sum as determinant
    logic               drain;  // wait for an empty pipeline before issue
  } uop_t;

  typedef struct packed {
    logic       issue;
    uop_t       op;
    logic       latch_in;
    logic       clr_sat;
    logic       load_out;
    logic [1:0] out_status;
  } kct_cmd_t;

  typedef struct packed {
    logic busy;
    logic det_pos;
    logic sat;
  } kct_sts_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SEQ, ST_CHK, ST_FIN} ctl_state_t;

  typedef enum logic [4:0] {
    PH_RSTX, PH_INITX, PH_IDP, PH_IDF, PH_DTF, PH_XP, PH_A, PH_PP, PH_Q, PH_E,
    PH_S, PH_DET, PH_INV, PH_K, PH_XN, PH_IDB, PH_BK, PH_PN, PH_CPX, PH_CPP
  } phase_t;

endpackage

// ----- hdl/kct_if.sv -----
interface kct_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, action, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, action, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface kct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_vx;
  logic signed [31:0] est_y;
  logic signed [31:0] est_vy;
  logic [1:0]         status;

  modport source (output valid, est_x, est_vx, est_y, est_vy, status, input ready);
  modport sink (input valid, est_x, est_vx, est_y, est_vy, status, output ready);
endinterface

// ----- hdl/kct_div.sv -----
module kct_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        neg,
  input  logic [31:0] mag,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [31:0] q,
  output logic        sat
);
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, done_r, neg_r, sat_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r, quo_fin;
  logic [63:0]   rem_r, den_r;
  logic [31:0]   q_r, q_nxt;
  logic [64:0]   trial, diff;
  logic          ge, ovf;

  // One quotient bit a cycle, restoring.
  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    quo_fin = {quo_r[NW-2:0], ge};
    if (neg_r) begin
      ovf   = (quo_fin > NW'(64'h8000_0000));
      q_nxt = ovf ? 32'h8000_0000 : 32'(~quo_fin + NW'(1));
    end else begin
      ovf   = (quo_fin > NW'(64'h7FFF_FFFF));
      q_nxt = ovf ? 32'h7FFF_FFFF : quo_fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {mag, FRAC_BITS'(0)};
      rem_r <= '0;
      den_r <= den;
      neg_r <= neg;
      cnt_r <= CW'(NW);
    end else if (busy_r) begin
      quo_r <= quo_fin;
      rem_r <= ge ? diff[63:0] : trial[63:0];
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        q_r   <= q_nxt;
        sat_r <= ovf;
      end
    end
  end

  assign busy = busy_r | done_r;
  assign done = done_r;
  assign q    = q_r;
  assign sat  = sat_r;

endmodule

// ----- hdl/kct_dp.sv -----
module kct_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kct_pkg::kct_cmd_t  cmd,
  output kct_pkg::kct_sts_t  sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  output logic signed [31:0] est_x,
  output logic signed [31:0] est_vx,
  output logic signed [31:0] est_y,
  output logic signed [31:0] est_vy,
  output logic [1:0]         status
);
  import kct_pkg::*;

  localparam logic [30:0] ONE31 = 31'(1) << FRAC_BITS;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;

  logic [30:0] dt_r, r_r, q_r;
  logic signed [31:0] px_r, py_r, vx_r, vy_r;

  logic [31:0] mem [MEM_DEPTH];

  logic               v1_r, v2_r, v3_r;
  uop_t               op1_r, op2_r, op3_r;
  logic signed [31:0] rda_r, rdb_r, opa;
  logic signed [63:0] prod, term_nxt, term_r, acc_r, det_r, base, acc_nxt;
  logic               ovf_hi, ovf_lo, act3;
  logic [31:0]        sat_val;

  logic               we, satw;
  logic [MEM_AW-1:0]  wadr, div_dst_r;
  logic [31:0]        wdat;
  logic               sat_r;
  logic signed [31:0] est_r [4];
  logic signed [31:0] out_r [4];
  logic [1:0]         out_status_r;

  logic               div_go, div_neg, div_busy, div_done, div_sat;
  logic [32:0]        a33, abs33;
  logic [31:0]        div_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= ONE31;
      r_r  <= ONE31;
      q_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TIME_STEP:  dt_r <= cfg_data;
        CFG_MEAS_NOISE: r_r  <= cfg_data;
        CFG_PROC_NOISE: q_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      vx_r <= in_vel_x;
      vy_r <= in_vel_y;
    end
  end

  // Stage 2: operand select and one product
  always_comb begin
    case (op2_r.src)
      SRC_DT:   opa = $signed({1'b0, dt_r});
      SRC_R:    opa = $signed({1'b0, r_r});
      SRC_Q:    opa = $signed({1'b0, q_r});
      SRC_ONE:  opa = $signed(ONE32);
      SRC_ZERO: opa = '0;
      SRC_PX:   opa = px_r;
      SRC_PY:   opa = py_r;
      SRC_VX:   opa = vx_r;
      SRC_VY:   opa = vy_r;
      default:  opa = rda_r;
    endcase
    prod = rda_r * rdb_r;
    case (op2_r.kind)
      K_MAC:   term_nxt = prod >>> FRAC_BITS;
      K_ADD:   term_nxt = {{32{opa[31]}}, opa};
      default: term_nxt = '0;
    endcase
  end

  // Stage 3: accumulate and saturate
  always_comb begin
    base    = op3_r.clr ? '0 : acc_r;
    acc_nxt = op3_r.neg ? base - term_r : base + term_r;
    ovf_hi  = (acc_nxt > 64'sd2147483647);
    ovf_lo  = (acc_nxt < -64'sd2147483648);
    sat_val = ovf_hi ? 32'h7FFF_FFFF : (ovf_lo ? 32'h8000_0000 : acc_nxt[31:0]);
    act3    = v3_r && (op3_r.kind == K_MAC || op3_r.kind == K_ADD);
    if (div_done) begin
      we   = 1'b1;
      wadr = div_dst_r;
      wdat = div_q;
      satw = div_sat;
    end else begin
      we   = act3 && op3_r.wr;
      wadr = op3_r.dst;
      wdat = sat_val;
      satw = ovf_hi | ovf_lo;
    end
  end

  // Divider operand: magnitude and sign of the (possibly negated) adjugate entry
  always_comb begin
    div_go  = v2_r && op2_r.kind == K_DIV;
    a33     = {rda_r[31], rda_r};
    abs33   = rda_r[31] ? -a33 : a33;
    div_neg = op2_r.neg ? (rda_r != '0 && !rda_r[31]) : rda_r[31];
  end

  kct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .neg   (div_neg),
    .mag   (abs33[31:0]),
    .den   (det_r),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q),
    .sat   (div_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op1_r <= cmd.op;
    end
    // Read both operands as the op moves into stage 2
    if (v1_r) begin
      rda_r <= mem[op1_r.a_adr];
      rdb_r <= mem[op1_r.b_adr];
    end
    if (we) begin
      mem[wadr] <= wdat;
    end
    op2_r  <= op1_r;
    op3_r  <= op2_r;
    term_r <= term_nxt;
    if (act3) begin
      acc_r <= acc_nxt;
      if (op3_r.det) begin
        det_r <= acc_nxt;
      end
    end
    if (div_go) begin
      div_dst_r <= op2_r.dst;
    end
    // Shadow the state vector for the result word
    if (we && (wadr >> 2) == (ADR_X >> 2)) begin
      est_r[wadr[1:0]] <= wdat;
    end
    if (cmd.load_out) begin
      out_r        <= est_r;
      out_status_r <= cmd.out_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.clr_sat) begin
        sat_r <= 1'b0;
      end else if (we && satw) begin
        sat_r <= 1'b1;
      end
    end
  end

  assign sts.busy    = v1_r | v2_r | v3_r | div_busy;
  assign sts.det_pos = (det_r > 64'sd0);
  assign sts.sat     = sat_r;

  assign est_x  = out_r[0];
  assign est_vx = out_r[1];
  assign est_y  = out_r[2];
  assign est_vy = out_r[3];
  assign status = out_status_r;

endmodule

// ----- hdl/kct_ctrl.sv -----
module kct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output kct_pkg::kct_cmd_t cmd,
  input  kct_pkg::kct_sts_t sts
);
  import kct_pkg::*;

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt, ph_next;
  logic [5:0] n_r, n_nxt;
  logic       boot_r, boot_nxt, ov_r, ov_nxt;
  logic [1:0] stat_r, stat_nxt;

  uop_t       op;
  logic       last, to_fin, to_chk;
  logic [1:0] ia, ja, ka, ib, jb;
  src_t       s_id, s_in;

  function automatic uop_t mk_op(kind_t k, src_t s, logic [MEM_AW-1:0] a,
                                 logic [MEM_AW-1:0] b, logic [MEM_AW-1:0] d,
                                 logic clr, logic neg, logic wr);
    uop_t o;
    o       = '0;
    o.kind  = k;
    o.src   = s;
    o.a_adr = a;
    o.b_adr = b;
    o.dst   = d;
    o.clr   = clr;
    o.neg   = neg;
    o.wr    = wr;
    return o;
  endfunction

  // Sequencer: one micro-op per step index of the current phase
  always_comb begin
    ia = n_r[5:4];
    ja = n_r[3:2];
    ka = n_r[1:0];
    ib = n_r[3:2];
    jb = n_r[1:0];
    s_id = (ib == jb) ? SRC_ONE : SRC_ZERO;
    case (jb)
      2'd0:    s_in = SRC_PX;
      2'd1:    s_in = SRC_VX;
      2'd2:    s_in = SRC_PY;
      default: s_in = SRC_VY;
    endcase
    op      = '0;
    last    = (n_r[3:0] == 4'd15);
    ph_next = phase_r;
    to_fin  = 1'b0;
    to_chk  = 1'b0;
    unique case (phase_r)
      PH_RSTX: begin
        op      = mk_op(K_ADD, SRC_ZERO, '0, '0, ADR_X + {5'd0, jb}, 1'b1, 1'b0, 1'b1);
        last    = (jb == 2'd3);
        ph_next = PH_IDP;
      end
      PH_INITX: begin
        op      = mk_op(K_ADD, s_in, '0, '0, ADR_X + {5'd0, jb}, 1'b1, 1'b0, 1'b1);
        last    = (jb == 2'd3);
        ph_next = PH_IDP;
      end
      PH_IDP: begin
        op     = mk_op(K_ADD, s_id, '0, '0, ADR_P + {3'd0, ib, jb}, 1'b1, 1'b0, 1'b1);
        to_fin = last;
      end
      PH_IDF: begin
        op      = mk_op(K_ADD, s_id, '0, '0, ADR_F + {3'd0, ib, jb}, 1'b1, 1'b0, 1'b1);
        ph_next = PH_DTF;
      end
      PH_DTF: begin
        // dt sits at F[0][1] and F[2][3]
        op      = mk_op(K_ADD, SRC_DT, '0, '0, n_r[0] ? ADR_F + 7'd11 : ADR_F + 7'd1,
                        1'b1, 1'b0, 1'b1);
        last    = n_r[0];
        ph_next = PH_XP;
      end
      PH_XP: begin
        op      = mk_op(K_MAC, SRC_MEM, ADR_F + {3'd0, ib, jb}, ADR_X + {5'd0, jb},
                        ADR_XP + {5'd0, ib}, jb == 2'd0, 1'b0, jb == 2'd3);
        ph_next = PH_A;
      end
      PH_A: begin
        op      = mk_op(K_MAC, SRC_MEM, ADR_F + {3'd0, ia, ka}, ADR_P + {3'd0, ka, ja},
                        ADR_A + {3'd0, ia, ja}, ka == 2'd0, 1'b0, ka == 2'd3);
        last    = (n_r == 6'd63);
        ph_next = PH_PP;
      end
      PH_PP: begin
        op      = mk_op(K_MAC, SRC_MEM, ADR_A + {3'd0, ia, ka}, ADR_F + {3'd0, ja, ka},
                        ADR_PP + {3'd0, ia, ja}, ka == 2'd0, 1'b0, ka == 2'd3);
        last    = (n_r == 6'd63);
        ph_next = PH_Q;
      end
      PH_Q: begin
        // add process noise on the diagonal
        if (!n_r[0]) begin
          op = mk_op(K_ADD, SRC_MEM, ADR_PP + {3'd0, n_r[2:1], n_r[2:1]}, '0, '0,
                     1'b1, 1'b0, 1'b0);
        end else begin
          op = mk_op(K_ADD, SRC_Q, '0, '0, ADR_PP + {3'd0, n_r[2:1], n_r[2:1]},
                     1'b0, 1'b0, 1'b1);
        end
        last    = (n_r[2:0] == 3'd7);
        ph_next = PH_E;
      end
      PH_E: begin
        if (!n_r[0]) begin
          op = mk_op(K_ADD, n_r[1] ? SRC_PY : SRC_PX, '0, '0, '0, 1'b1, 1'b0, 1'b0);
        end else begin
          op = mk_op(K_ADD, SRC_MEM, ADR_XP + {5'd0, n_r[1], 1'b0}, '0,
                     ADR_E + {6'd0, n_r[1]}, 1'b0, 1'b1, 1'b1);
        end
        last    = (n_r[1:0] == 2'd3);
        ph_next = PH_S;
      end
      PH_S: begin
        case (n_r[2:0])
          3'd0:    op = mk_op(K_ADD, SRC_MEM, ADR_PP, '0, '0, 1'b1, 1'b0, 1'b0);
          3'd1:    op = mk_op(K_ADD, SRC_R, '0, '0, ADR_S, 1'b0, 1'b0, 1'b1);
          3'd2:    op = mk_op(K_ADD, SRC_MEM, ADR_PP + 7'd2, '0, ADR_S + 7'd1,
                              1'b1, 1'b0, 1'b1);
          3'd3:    op = mk_op(K_ADD, SRC_MEM, ADR_PP + 7'd8, '0, ADR_S + 7'd2,
                              1'b1, 1'b0, 1'b1);
          3'd4:    op = mk_op(K_ADD, SRC_MEM, ADR_PP + 7'd10, '0, '0, 1'b1, 1'b0, 1'b0);
          default: op = mk_op(K_ADD, SRC_R, '0, '0, ADR_S + 7'd3, 1'b0, 1'b0, 1'b1);
        endcase
        last    = (n_r[2:0] == 3'd5);
        ph_next = PH_DET;
      end
      PH_DET: begin
        if (!n_r[0]) begin
          op = mk_op(K_MAC, SRC_MEM, ADR_S, ADR_S + 7'd3, '0, 1'b1, 1'b0, 1'b0);
        end else begin
          op     = mk_op(K_MAC, SRC_MEM, ADR_S + 7'd1, ADR_S + 7'd2, '0, 1'b0, 1'b1, 1'b0);
          op.det = 1'b1;
        end
        last   = n_r[0];
        to_chk = n_r[0];
      end
      PH_INV: begin
        // adjugate: s11, -s01, -s10, s00
        case (jb)
          2'd0:    op = mk_op(K_DIV, SRC_MEM, ADR_S + 7'd3, '0, ADR_SI, 1'b0, 1'b0, 1'b0);
          2'd1:    op = mk_op(K_DIV, SRC_MEM, ADR_S + 7'd1, '0, ADR_SI + 7'd1,
                              1'b0, 1'b1, 1'b0);
          2'd2:    op = mk_op(K_DIV, SRC_MEM, ADR_S + 7'd2, '0, ADR_SI + 7'd2,
                              1'b0, 1'b1, 1'b0);
          default: op = mk_op(K_DIV, SRC_MEM, ADR_S, '0, ADR_SI + 7'd3, 1'b0, 1'b0, 1'b0);
        endcase
        last    = (jb == 2'd3);
        ph_next = PH_K;
      end
      PH_K: begin
        op      = mk_op(K_MAC, SRC_MEM, ADR_PP + {3'd0, ib, n_r[0], 1'b0},
                        ADR_SI + {5'd0, n_r[0], n_r[1]}, ADR_K + {4'd0, ib, n_r[1]},
                        !n_r[0], 1'b0, n_r[0]);
        ph_next = PH_XN;
      end
      PH_XN: begin
        case (jb)
          2'd0:    op = mk_op(K_ADD, SRC_MEM, ADR_XP + {5'd0, ib}, '0, '0,
                              1'b1, 1'b0, 1'b0);
          2'd1:    op = mk_op(K_MAC, SRC_MEM, ADR_K + {4'd0, ib, 1'b0}, ADR_E, '0,
                              1'b0, 1'b0, 1'b0);
          2'd2:    op = mk_op(K_MAC, SRC_MEM, ADR_K + {4'd0, ib, 1'b1}, ADR_E + 7'd1,
                              ADR_XN + {5'd0, ib}, 1'b0, 1'b0, 1'b1);
          default: op = '0;
        endcase
        ph_next = PH_IDB;
      end
      PH_IDB: begin
        op      = mk_op(K_ADD, s_id, '0, '0, ADR_B + {3'd0, ib, jb}, 1'b1, 1'b0, 1'b1);
        ph_next = PH_BK;
      end
      PH_BK: begin
        if (!n_r[0]) begin
          op = mk_op(K_ADD, SRC_MEM, ADR_B + {3'd0, ib, n_r[1], 1'b0}, '0, '0,
                     1'b1, 1'b0, 1'b0);
        end else begin
          op = mk_op(K_ADD, SRC_MEM, ADR_K + {4'd0, ib, n_r[1]}, '0,
                     ADR_B + {3'd0, ib, n_r[1], 1'b0}, 1'b0, 1'b1, 1'b1);
        end
        ph_next = PH_PN;
      end
      PH_PN: begin
        op      = mk_op(K_MAC, SRC_MEM, ADR_B + {3'd0, ia, ka}, ADR_PP + {3'd0, ka, ja},
                        ADR_PN + {3'd0, ia, ja}, ka == 2'd0, 1'b0, ka == 2'd3);
        last    = (n_r == 6'd63);
        ph_next = PH_CPX;
      end
      PH_CPX: begin
        op      = mk_op(K_ADD, SRC_MEM, ADR_XN + {5'd0, jb}, '0, ADR_X + {5'd0, jb},
                        1'b1, 1'b0, 1'b1);
        last    = (jb == 2'd3);
        ph_next = PH_CPP;
      end
      PH_CPP: begin
        op     = mk_op(K_ADD, SRC_MEM, ADR_PN + {3'd0, ib, jb}, '0, ADR_P + {3'd0, ib, jb},
                       1'b1, 1'b0, 1'b1);
        to_fin = last;
      end
      default: ;
    endcase
    op.drain = (n_r == 6'd0) || (op.kind == K_DIV);
  end

  // Control state machine
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    n_nxt     = n_r;
    boot_nxt  = boot_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.op    = op;
    cmd.out_status = (stat_r == STS_OK && sts.sat) ? STS_SAT : stat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.clr_sat  = 1'b1;
          stat_nxt     = STS_OK;
          n_nxt        = '0;
          phase_nxt    = in_action ? PH_IDF : PH_INITX;
          state_nxt    = ST_SEQ;
        end
      end
      ST_SEQ: begin
        if (op.kind == K_NOP || !op.drain || !sts.busy) begin
          cmd.issue = (op.kind != K_NOP);
          if (last) begin
            n_nxt     = '0;
            phase_nxt = ph_next;
            if (to_fin) begin
              state_nxt = ST_FIN;
            end else if (to_chk) begin
              state_nxt = ST_CHK;
            end
          end else begin
            n_nxt = n_r + 6'd1;
          end
        end
      end
      ST_CHK: begin
        if (!sts.busy) begin
          if (sts.det_pos) begin
            phase_nxt = PH_INV;
            n_nxt     = '0;
            state_nxt = ST_SEQ;
          end else begin
            // singular: drop the update, keep the state
            stat_nxt  = STS_SING;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!sts.busy) begin
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else if (!ov_r || out_ready) begin
            cmd.load_out = 1'b1;
            ov_nxt       = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEQ;
      phase_r <= PH_RSTX;
      n_r     <= '0;
      boot_r  <= 1'b1;
      stat_r  <= STS_OK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      n_r     <= n_nxt;
      boot_r  <= boot_nxt;
      stat_r  <= stat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

endmodule

// ----- hdl/kalman_cv_tracker_2d.sv -----
// Channel  | Dir | Word contents                                   | Handshake
// in_ch    | in  | action, pos_x, pos_y, vel_x, vel_y              | valid/ready
// out_ch   | out | est_x, est_vx, est_y, est_vy, status            | valid/ready
// cfg_*    | in  | cfg_idx (0 time_step, 1 meas_noise, 2 proc_noise), cfg_data | cfg_we
//
// A start word loads the state and an identity covariance; a measurement word runs
// multiply-accumulate micro-ops, with pipeline drains between
// phases, plus four divisions of 32 + FRAC_BITS quotient bits each (48 bits at
// Q16.16). The single multiply-accumulate pipeline and the
// bit-serial divider set the length of a word's run.
// After reset the sequencer writes a zero state and an identity covariance into
// the scratch memory; no input word is taken then.
// A finished result waits in the output register; the next input word is taken
// meanwhile, and its result is held back until the previous one is taken.
module kalman_cv_tracker_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  kct_in_if.sink      in_ch,
  kct_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_data
);
  import kct_pkg::*;

  kct_cmd_t cmd;
  kct_sts_t sts;

  // Sequencer: walks the predict / correct micro-op phases
  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: scratch memory, MAC pipeline, divider, config and result registers
  kct_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_pos_x (in_ch.pos_x),
    .in_pos_y (in_ch.pos_y),
    .in_vel_x (in_ch.vel_x),
    .in_vel_y (in_ch.vel_y),
    .est_x    (out_ch.est_x),
    .est_vx   (out_ch.est_vx),
    .est_y    (out_ch.est_y),
    .est_vy   (out_ch.est_vy),
    .status   (out_ch.status)
  );

`ifndef ASSERT_OFF
  // Ready only with the datapath drained
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.busy)
    else $error("input ready while datapath busy");

  // One word at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accept");

  // Result captured only after every write has landed
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.busy)
    else $error("result loaded with pipeline busy");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import kct_pkg::*;

  localparam int FRAC = 16;
  localparam int ONE = 1 << FRAC;
  localparam int ITEMS = 700;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [30:0] cfg_data;

  kct_in_if in_ch ();
  kct_out_if out_ch ();

  kalman_cv_tracker_2d #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  // One estimate word as the tracker reports it.
  typedef struct {
    int x;
    int vx;
    int y;
    int vy;
    logic [1:0] st;
  } est_t;

  typedef int mat_t[16];

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

  // Directed stimulus: a word (with an optional typed expectation) or a
  // register write (a = index, b = value).
  typedef struct {
    row_kind_t kind;
    bit act;
    int a;
    int b;
    int c;
    int d;
    bit typed;
    est_t want;
  } row_t;

  // Tracker image kept by the testbench.
  int trk_x[4];
  mat_t trk_p;
  int unsigned dt_reg, r_reg, q_reg;
  bit clipped;

  est_t est_fifo[$];
  int errors = 0;
  int words_sent = 0;
  int snd_idle = 16;
  int rcv_idle = 83;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Saturate a sum to 32-bit signed and note it.
  function automatic int clip(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  // Fixed-point product, floor rounding.
  function automatic longint qmul(int a, int b);
    return (longint'(a) * longint'(b)) >>> FRAC;
  endfunction

  function automatic mat_t mmul(mat_t a, mat_t b, bit tr);
    mat_t c;
    longint acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc += qmul(a[i*4+k], tr ? b[j*4+k] : b[k*4+j]);
        c[i*4+j] = clip(acc);
      end
    end
    return c;
  endfunction

  function automatic mat_t eye();
    mat_t m;
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
    return m;
  endfunction

  // One predict and correct pass; returns the status code.
  function automatic logic [1:0] track_correct(int zx, int zy);
    mat_t f, a, pp, b, pn;
    int xp[4], xn[4], kg[4][2], e[2], s[2][2], si[2][2];
    longint det, acc, adj[2][2];
    int dt, r, q;
    dt = int'(dt_reg);
    r = int'(r_reg);
    q = int'(q_reg);
    clipped = 1'b0;
    f = eye();
    f[1] = dt;
    f[11] = dt;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += qmul(f[i*4+j], trk_x[j]);
      xp[i] = clip(acc);
    end
    a = mmul(f, trk_p, 1'b0);
    pp = mmul(a, f, 1'b1);
    for (int i = 0; i < 4; i++) pp[i*5] = clip(longint'(pp[i*5]) + q);
    e[0] = clip(longint'(zx) - xp[0]);
    e[1] = clip(longint'(zy) - xp[2]);
    s[0][0] = clip(longint'(pp[0]) + r);
    s[0][1] = pp[2];
    s[1][0] = pp[8];
    s[1][1] = clip(longint'(pp[10]) + r);
    det = qmul(s[0][0], s[1][1]) - qmul(s[0][1], s[1][0]);
    if (det <= 0) return STS_SING;
    adj[0][0] = s[1][1];
    adj[0][1] = -longint'(s[0][1]);
    adj[1][0] = -longint'(s[1][0]);
    adj[1][1] = s[0][0];
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        si[i][j] = clip((adj[i][j] * longint'(ONE)) / det);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 2; j++)
        kg[i][j] = clip(qmul(pp[i*4], si[0][j]) + qmul(pp[i*4+2], si[1][j]));
    for (int i = 0; i < 4; i++)
      xn[i] = clip(longint'(xp[i]) + qmul(kg[i][0], e[0]) + qmul(kg[i][1], e[1]));
    b = eye();
    for (int i = 0; i < 4; i++) begin
      b[i*4] = clip(longint'(b[i*4]) - kg[i][0]);
      b[i*4+2] = clip(longint'(b[i*4+2]) - kg[i][1]);
    end
    pn = mmul(b, pp, 1'b0);
    trk_x = xn;
    trk_p = pn;
    return clipped ? STS_SAT : STS_OK;
  endfunction

  function automatic est_t track_word(bit act, int px, int py, int vx, int vy);
    est_t r;
    r.st = STS_OK;
    if (!act) begin
      trk_x[0] = px;
      trk_x[1] = vx;
      trk_x[2] = py;
      trk_x[3] = vy;
      trk_p = eye();
    end else begin
      r.st = track_correct(px, py);
    end
    r.x = trk_x[0];
    r.vx = trk_x[1];
    r.y = trk_x[2];
    r.vy = trk_x[3];
    return r;
  endfunction

  // Send one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(bit act, int px, int py, int vx, int vy, bit typed, est_t want);
    est_t got;
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    do @(posedge clk); while (!in_ch.ready);
    got = track_word(act, px, py, vx, vy);
    est_fifo.push_back(typed ? want : got);
    words_sent++;
    @(negedge clk);
  endtask

  // Drain every pending estimate, then let the sequencer settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (est_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_set(logic [1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[30:0];
    case (idx)
      CFG_TIME_STEP: dt_reg = val & 32'h7fffffff;
      CFG_MEAS_NOISE: r_reg = val & 32'h7fffffff;
      CFG_PROC_NOISE: q_reg = val & 32'h7fffffff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of full-range, small, extreme and mid-size Q16.16 values.
  function automatic int pick_val();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return int'($urandom_range(32'h7ffff)) - 32'sh40000;
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(32'hffffff)) - 32'sh800000;
    endcase
  endfunction

  function automatic est_t mk(int x, int vx, int y, int vy, logic [1:0] st);
    est_t r;
    r.x = x;
    r.vx = vx;
    r.y = y;
    r.vy = vy;
    r.st = st;
    return r;
  endfunction

  // Receiver: drop ready at random according to the current mode.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Compare each taken estimate word against the oldest expectation.
  always @(posedge clk) begin
    est_t w;
    longint e[5], a[5];
    string nm[5];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (est_fifo.size() == 0) begin
        $display("%0t: unexpected word x=%h vx=%h y=%h vy=%h st=%0d", $realtime,
                 out_ch.est_x, out_ch.est_vx, out_ch.est_y, out_ch.est_vy, out_ch.status);
        errors++;
      end else begin
        w = est_fifo.pop_front();
        nm = '{"est_x", "est_vx", "est_y", "est_vy", "status"};
        e = '{w.x, w.vx, w.y, w.vy, w.st};
        a = '{out_ch.est_x, out_ch.est_vx, out_ch.est_y, out_ch.est_vy, out_ch.status};
        for (int i = 0; i < 5; i++) begin
          if (e[i] != a[i]) begin
            $display("%0t: %s mismatch expected %h actual %h", $realtime, nm[i],
                     e[i][31:0], a[i][31:0]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("kalman_cv_tracker_2d verification failed");
        $finish;
      end
    end
  end

  initial begin
    row_t tab[$];
    est_t none;
    int unsigned ph_dt[4], ph_r[4], ph_q[4];
    int px, py, n;
    none = mk(0, 0, 0, 0, STS_OK);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TIME_STEP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.pos_x = 0;
    in_ch.pos_y = 0;
    in_ch.vel_x = 0;
    in_ch.vel_y = 0;
    out_ch.ready = 1'b0;
    dt_reg = ONE;
    r_reg = ONE;
    q_reg = 0;
    trk_x = '{0, 0, 0, 0};
    trk_p = eye();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: update from the reset state, extremes of every field,
    // ignored velocity on update, a singular innovation covariance and process noise.
    tab.push_back('{ROW_WORD, 1, 0, 0, 0, 0, 1, none});
    tab.push_back('{ROW_WORD, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                    1, mk(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, STS_OK)});
    tab.push_back('{ROW_WORD, 1, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, none});
    tab.push_back('{ROW_WORD, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                    1, mk(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, STS_OK)});
    tab.push_back('{ROW_WORD, 1, 0, 0, 0, 0, 0, none});
    tab.push_back('{ROW_WORD, 0, 0, 0, ONE, -ONE, 1, mk(0, ONE, 0, -ONE, STS_OK)});
    tab.push_back('{ROW_WORD, 1, ONE, -ONE, 32'sh12345678, -77, 0, none});
    tab.push_back('{ROW_WORD, 1, 2*ONE, -2*ONE, 32'sh7fffffff, 32'sh80000000, 0, none});
    tab.push_back('{ROW_WORD, 1, 32'sh80000000, 32'sh7fffffff, -1, -1, 0, none});
    // dt = 0 and R = 0: the first update pins the position variances to
    // zero, so the next one sees a zero determinant and keeps the state.
    tab.push_back('{ROW_CFG, 0, CFG_TIME_STEP, 0, 0, 0, 0, none});
    tab.push_back('{ROW_CFG, 0, CFG_MEAS_NOISE, 0, 0, 0, 0, none});
    tab.push_back('{ROW_WORD, 0, ONE, 3*ONE, 2*ONE, 4*ONE, 1, mk(ONE, 2*ONE, 3*ONE, 4*ONE, STS_OK)});
    tab.push_back('{ROW_WORD, 1, 5*ONE, 6*ONE, 0, 0, 1, mk(5*ONE, 2*ONE, 6*ONE, 4*ONE, STS_OK)});
    tab.push_back('{ROW_WORD, 1, 9*ONE, -9*ONE, 0, 0, 1,
                    mk(5*ONE, 2*ONE, 6*ONE, 4*ONE, STS_SING)});
    tab.push_back('{ROW_CFG, 0, CFG_TIME_STEP, ONE, 0, 0, 0, none});
    tab.push_back('{ROW_CFG, 0, CFG_MEAS_NOISE, ONE, 0, 0, 0, none});
    tab.push_back('{ROW_CFG, 0, CFG_PROC_NOISE, ONE, 0, 0, 0, none});
    tab.push_back('{ROW_WORD, 0, -ONE, ONE, ONE/2, -ONE/2, 1, mk(-ONE, ONE/2, ONE, -ONE/2, STS_OK)});
    tab.push_back('{ROW_WORD, 1, 0, 2*ONE, 0, 0, 0, none});
    tab.push_back('{ROW_WORD, 1, ONE, 3*ONE, 0, 0, 0, none});
    tab.push_back('{ROW_CFG, 0, CFG_PROC_NOISE, 0, 0, 0, 0, none});

    foreach (tab[i]) begin
      if (tab[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_set(tab[i].a[1:0], tab[i].b);
      end else begin
        send_word(tab[i].act, tab[i].a, tab[i].b, tab[i].c, tab[i].d,
                  tab[i].typed, tab[i].want);
      end
    end

    // Random part: four register settings, extremes among them. Most words
    // are tracks (a start followed by measurements near the estimate).
    ph_dt = '{ONE, 0, 32'h7fffffff, $urandom_range(32'h20000)};
    ph_r = '{ONE, 0, 32'h7fffffff, $urandom_range(32'h40000)};
    ph_q = '{0, 0, 32'h7fffffff, $urandom_range(32'h1000)};
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      cfg_set(CFG_TIME_STEP, ph_dt[ph]);
      cfg_set(CFG_MEAS_NOISE, ph_r[ph]);
      cfg_set(CFG_PROC_NOISE, ph_q[ph]);
      while (words_sent < (ph + 1) * ITEMS / 4 + tab.size()) begin
        // Hold the idling mode to the share of words already sent.
        if (words_sent < ITEMS / 3) begin
          snd_idle = 16;
          rcv_idle = 83;
        end else if (words_sent < 2 * ITEMS / 3) begin
          snd_idle = 83;
          rcv_idle = 16;
        end else begin
          snd_idle = 0;
          rcv_idle = 0;
        end
        if ($urandom_range(9) < 8) begin
          send_word(1'b0, pick_val(), pick_val(), pick_val(), pick_val(), 1'b0, none);
          n = $urandom_range(8, 1);
          for (int k = 0; k < n; k++) begin
            px = int'(longint'(trk_x[0]) + $urandom_range(32'h3ffff) - 32'h20000);
            py = int'(longint'(trk_x[2]) + $urandom_range(32'h3ffff) - 32'h20000);
            send_word(1'b1, px, py, int'($urandom), int'($urandom), 1'b0, none);
          end
        end else begin
          send_word($urandom_range(1), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), 1'b0, none);
        end
      end
    end

    // Drain and let the last word settle.
    wait_idle();
    if (errors == 0) begin
      $display("kalman_cv_tracker_2d verification clean");
    end else begin
      $display("kalman_cv_tracker_2d verification failed");
    end
    $finish;
  end

endmodule
